/* rtl/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define TCPQ_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define TCPQ_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tcpq_pkg.sv */
// ----------------------------------------------------------------------------
// tcpq_pkg
// Shared types, sizes, codes and helpers of the two-class priority queue.
// ----------------------------------------------------------------------------
package tcpq_pkg;

    // sizing
    localparam int QUEUE_DEPTH = 16;
    localparam int HIST_DEPTH  = 64;
    localparam int ID_BITS     = 10;

    // fixed item field widths
    localparam int ID_FIELD_W  = 10;
    localparam int REF_W       = 16;
    localparam int CNT_FIELD_W = 5;

    // derived widths
    localparam int QA_W   = $clog2(QUEUE_DEPTH);
    localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int HA_W   = $clog2(HIST_DEPTH);
    localparam int HC_W   = $clog2(HIST_DEPTH + 1);
    localparam int SA_W   = (QA_W > HA_W) ? QA_W : HA_W;
    localparam int SL_W   = (QC_W > HC_W) ? QC_W : HC_W;
    localparam int ENTRY_W = ID_BITS + REF_W;

    // request kinds
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_SERVE  = 2'd1;
    localparam logic [1:0] KIND_PEEK   = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_DUP   = 2'd2;
    localparam logic [1:0] STAT_FULL  = 2'd3;

    // request item
    typedef struct packed {
        logic [1:0]            kind;
        logic [ID_FIELD_W-1:0] pet_id;
        logic [REF_W-1:0]      record_ref;
        logic                  priority_class;
    } req_t;

    // result item
    typedef struct packed {
        logic [1:0]             status;
        logic [ID_FIELD_W-1:0]  out_id;
        logic [REF_W-1:0]       out_record_ref;
        logic                   out_class;
        logic [CNT_FIELD_W-1:0] urgent_count;
        logic [CNT_FIELD_W-1:0] normal_count;
    } rsp_t;

    // control of the id compare unit
    typedef struct packed {
        logic clear;
        logic en;
    } match_ctl_t;

    // next queue slot with wrap
    function automatic logic [QA_W-1:0] step_q(input logic [QA_W-1:0] i);
        logic [QA_W-1:0] r;
        if (i == QA_W'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = i + QA_W'(1);
        return r;
    endfunction

    // next history slot with wrap
    function automatic logic [HA_W-1:0] step_h(input logic [HA_W-1:0] i);
        logic [HA_W-1:0] r;
        if (i == HA_W'(HIST_DEPTH - 1))
            r = '0;
        else
            r = i + HA_W'(1);
        return r;
    endfunction

endpackage

/* rtl/tcpq_ram.sv */
// ----------------------------------------------------------------------------
// tcpq_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module tcpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/tcpq_match.sv */
// ----------------------------------------------------------------------------
// tcpq_match
// Shared id compare unit: one stored id per cycle against the key.
// ----------------------------------------------------------------------------
module tcpq_match (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tcpq_pkg::match_ctl_t        ctl,
    input  logic [tcpq_pkg::ID_BITS-1:0] key,
    input  logic [tcpq_pkg::ID_BITS-1:0] data,
    output logic                        hit
);

    logic hit_reg;
    logic hit_next;

    // sticky hit flag, cleared at the start of a scan
    always_comb
    begin
        hit_next = hit_reg;
        if (ctl.clear)
            hit_next = 1'b0;
        else if (ctl.en && (data == key))
            hit_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hit_reg <= 1'b0;
        else
            hit_reg <= hit_next;
    end

    assign hit = hit_reg;

endmodule

/* rtl/two_class_priority_queue_top.sv */
// ----------------------------------------------------------------------------
// two_class_priority_queue_top
// Urgent and normal FIFOs with strict-priority service and a served-id ring.
// ----------------------------------------------------------------------------
// Usage:
// - req channel (req_valid/req_stall/req) takes insert, serve and peek items;
//   rsp channel (rsp_valid/rsp_stall/rsp) returns one result item for each.
// - req_stall is high while an item is being worked on; one item at a time.
// - insert: the id is compared against every waiting urgent entry, every
//   waiting normal entry and every history entry, one per cycle through a
//   single compare unit.
// - serve and peek read the head entry from the queue memory; empty queues
//   and unused kinds go straight to the result.
// - the result sits in an output register; the next item can be accepted
//   while it waits. If the receiver stalls and a second result is ready,
//   that result waits in the sequencer until the register frees up.
// - reset clears queue pointers, counts, history pointers and the output
//   valid; memories are not cleared and are only read where written.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module two_class_priority_queue_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  tcpq_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output tcpq_pkg::rsp_t rsp
);

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN_U = 3'd1;
    localparam logic [2:0] ST_SCAN_N = 3'd2;
    localparam logic [2:0] ST_SCAN_H = 3'd3;
    localparam logic [2:0] ST_DECIDE = 3'd4;
    localparam logic [2:0] ST_HEAD   = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    // scan sources
    localparam logic [1:0] SRC_U = 2'd0;
    localparam logic [1:0] SRC_N = 2'd1;
    localparam logic [1:0] SRC_H = 2'd2;

    localparam int IDB = tcpq_pkg::ID_BITS;
    localparam int QAW = tcpq_pkg::QA_W;
    localparam int QCW = tcpq_pkg::QC_W;
    localparam int HAW = tcpq_pkg::HA_W;
    localparam int HCW = tcpq_pkg::HC_W;
    localparam int SAW = tcpq_pkg::SA_W;
    localparam int SLW = tcpq_pkg::SL_W;
    localparam int EW  = tcpq_pkg::ENTRY_W;
    localparam int RW  = tcpq_pkg::REF_W;

    logic [2:0]     state_reg, state_next;

    // queue pointers
    logic [QAW-1:0] u_head_reg, u_head_next, u_tail_reg, u_tail_next;
    logic [QCW-1:0] u_count_reg, u_count_next;
    logic [QAW-1:0] n_head_reg, n_head_next, n_tail_reg, n_tail_next;
    logic [QCW-1:0] n_count_reg, n_count_next;

    // history pointers
    logic [HAW-1:0] h_wr_reg, h_wr_next;
    logic [HCW-1:0] h_count_reg, h_count_next;

    // scan control
    logic [SAW-1:0] scan_addr_reg, scan_addr_next;
    logic [SLW-1:0] scan_left_reg, scan_left_next;
    logic           pend_reg, pend_next;
    logic [1:0]     src_reg, src_next;

    // captured request
    logic [IDB-1:0] key_reg, key_next;
    logic [RW-1:0]  ref_reg, ref_next;
    logic           cls_reg, cls_next;
    logic           serve_reg, serve_next;

    // result being built
    logic [1:0]     res_status_reg, res_status_next;
    logic [IDB-1:0] res_id_reg, res_id_next;
    logic [RW-1:0]  res_ref_reg, res_ref_next;
    logic           res_cls_reg, res_cls_next;

    // output register
    logic           rsp_valid_reg, rsp_valid_next;
    tcpq_pkg::rsp_t rsp_reg, rsp_next;

    // memory ports
    logic           u_we, n_we, h_we;
    logic [QAW-1:0] u_waddr, n_waddr, u_raddr, n_raddr;
    logic [EW-1:0]  q_wdata, u_rdata, n_rdata;
    logic [IDB-1:0] h_rdata, h_wdata;

    // compare unit
    tcpq_pkg::match_ctl_t mctl;
    logic [IDB-1:0]       cmp_data;
    logic                 hit;
    logic                 can_load;
    logic                 accept;
    logic [EW-1:0]        head_entry;

    assign accept   = req_valid && !req_stall;
    assign can_load = !rsp_valid_reg || !rsp_stall;

    // memory addressing: scan address while scanning, head otherwise
    assign u_raddr = (state_reg == ST_SCAN_U) ? scan_addr_reg[QAW-1:0] : u_head_reg;
    assign n_raddr = (state_reg == ST_SCAN_N) ? scan_addr_reg[QAW-1:0] : n_head_reg;
    assign q_wdata = {key_reg, ref_reg};
    assign u_waddr = u_tail_reg;
    assign n_waddr = n_tail_reg;
    assign head_entry = res_cls_reg ? n_rdata : u_rdata;
    assign h_wdata = head_entry[EW-1:RW];

    tcpq_ram #(.WIDTH(EW), .DEPTH(tcpq_pkg::QUEUE_DEPTH)) u_urgent_ram (
        .clk   (clk),
        .we    (u_we),
        .waddr (u_waddr),
        .wdata (q_wdata),
        .raddr (u_raddr),
        .rdata (u_rdata)
    );

    tcpq_ram #(.WIDTH(EW), .DEPTH(tcpq_pkg::QUEUE_DEPTH)) u_normal_ram (
        .clk   (clk),
        .we    (n_we),
        .waddr (n_waddr),
        .wdata (q_wdata),
        .raddr (n_raddr),
        .rdata (n_rdata)
    );

    tcpq_ram #(.WIDTH(IDB), .DEPTH(tcpq_pkg::HIST_DEPTH)) u_hist_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_wr_reg),
        .wdata (h_wdata),
        .raddr (scan_addr_reg[HAW-1:0]),
        .rdata (h_rdata)
    );

    // compare data follows the source of the read issued last cycle
    always_comb
    begin
        unique case (src_reg)
            SRC_U:   cmp_data = u_rdata[EW-1:RW];
            SRC_N:   cmp_data = n_rdata[EW-1:RW];
            default: cmp_data = h_rdata;
        endcase
    end

    assign mctl.clear = accept;
    assign mctl.en    = pend_reg;

    tcpq_match u_match (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mctl),
        .key   (key_reg),
        .data  (cmp_data),
        .hit   (hit)
    );

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        u_head_next     = u_head_reg;
        u_tail_next     = u_tail_reg;
        u_count_next    = u_count_reg;
        n_head_next     = n_head_reg;
        n_tail_next     = n_tail_reg;
        n_count_next    = n_count_reg;
        h_wr_next       = h_wr_reg;
        h_count_next    = h_count_reg;
        scan_addr_next  = scan_addr_reg;
        scan_left_next  = scan_left_reg;
        pend_next       = 1'b0;
        src_next        = src_reg;
        key_next        = key_reg;
        ref_next        = ref_reg;
        cls_next        = cls_reg;
        serve_next      = serve_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_ref_next    = res_ref_reg;
        res_cls_next    = res_cls_reg;
        u_we            = 1'b0;
        n_we            = 1'b0;
        h_we            = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    key_next        = req.pet_id[IDB-1:0];
                    ref_next        = req.record_ref;
                    cls_next        = req.priority_class;
                    serve_next      = (req.kind == tcpq_pkg::KIND_SERVE);
                    res_status_next = tcpq_pkg::STAT_OK;
                    res_id_next     = '0;
                    res_ref_next    = '0;
                    res_cls_next    = 1'b0;
                    if (req.kind == tcpq_pkg::KIND_INSERT)
                    begin
                        scan_addr_next = SAW'(u_head_reg);
                        scan_left_next = SLW'(u_count_reg);
                        state_next     = ST_SCAN_U;
                    end
                    else if (req.kind == tcpq_pkg::KIND_SERVE ||
                             req.kind == tcpq_pkg::KIND_PEEK)
                    begin
                        if (u_count_reg != '0)
                        begin
                            res_cls_next = 1'b0;
                            state_next   = ST_HEAD;
                        end
                        else if (n_count_reg != '0)
                        begin
                            res_cls_next = 1'b1;
                            state_next   = ST_HEAD;
                        end
                        else
                        begin
                            res_status_next = tcpq_pkg::STAT_EMPTY;
                            state_next      = ST_FINISH;
                        end
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            // walk the waiting urgent entries from the head
            ST_SCAN_U:
            begin
                if (scan_left_reg != '0)
                begin
                    pend_next      = 1'b1;
                    src_next       = SRC_U;
                    scan_addr_next = SAW'(tcpq_pkg::step_q(scan_addr_reg[QAW-1:0]));
                    scan_left_next = scan_left_reg - SLW'(1);
                end
                else
                begin
                    scan_addr_next = SAW'(n_head_reg);
                    scan_left_next = SLW'(n_count_reg);
                    state_next     = ST_SCAN_N;
                end
            end

            // walk the waiting normal entries from the head
            ST_SCAN_N:
            begin
                if (scan_left_reg != '0)
                begin
                    pend_next      = 1'b1;
                    src_next       = SRC_N;
                    scan_addr_next = SAW'(tcpq_pkg::step_q(scan_addr_reg[QAW-1:0]));
                    scan_left_next = scan_left_reg - SLW'(1);
                end
                else
                begin
                    scan_addr_next = '0;
                    scan_left_next = SLW'(h_count_reg);
                    state_next     = ST_SCAN_H;
                end
            end

            // walk the written history slots
            ST_SCAN_H:
            begin
                if (scan_left_reg != '0)
                begin
                    pend_next      = 1'b1;
                    src_next       = SRC_H;
                    scan_addr_next = scan_addr_reg + SAW'(1);
                    scan_left_next = scan_left_reg - SLW'(1);
                end
                else
                begin
                    state_next = ST_DECIDE;
                end
            end

            // duplicate first, then full, else write at the tail
            ST_DECIDE:
            begin
                if (hit)
                    res_status_next = tcpq_pkg::STAT_DUP;
                else if (!cls_reg && u_count_reg >= QCW'(tcpq_pkg::QUEUE_DEPTH))
                    res_status_next = tcpq_pkg::STAT_FULL;
                else if (cls_reg && n_count_reg >= QCW'(tcpq_pkg::QUEUE_DEPTH))
                    res_status_next = tcpq_pkg::STAT_FULL;
                else if (!cls_reg)
                begin
                    u_we         = 1'b1;
                    u_tail_next  = tcpq_pkg::step_q(u_tail_reg);
                    u_count_next = u_count_reg + QCW'(1);
                end
                else
                begin
                    n_we         = 1'b1;
                    n_tail_next  = tcpq_pkg::step_q(n_tail_reg);
                    n_count_next = n_count_reg + QCW'(1);
                end
                state_next = ST_FINISH;
            end

            // head entry is on the read port; pop and log on serve
            ST_HEAD:
            begin
                res_id_next  = head_entry[EW-1:RW];
                res_ref_next = head_entry[RW-1:0];
                if (serve_reg)
                begin
                    h_we      = 1'b1;
                    h_wr_next = tcpq_pkg::step_h(h_wr_reg);
                    if (h_count_reg < HCW'(tcpq_pkg::HIST_DEPTH))
                        h_count_next = h_count_reg + HCW'(1);
                    if (!res_cls_reg)
                    begin
                        u_head_next  = tcpq_pkg::step_q(u_head_reg);
                        u_count_next = u_count_reg - QCW'(1);
                    end
                    else
                    begin
                        n_head_next  = tcpq_pkg::step_q(n_head_reg);
                        n_count_next = n_count_reg - QCW'(1);
                    end
                end
                state_next = ST_FINISH;
            end

            // hand the result to the output register once it is free
            ST_FINISH:
            begin
                if (can_load)
                    state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (state_reg == ST_FINISH && can_load)
        begin
            rsp_valid_next          = 1'b1;
            rsp_next.status         = res_status_reg;
            rsp_next.out_id         = tcpq_pkg::ID_FIELD_W'(res_id_reg);
            rsp_next.out_record_ref = res_ref_reg;
            rsp_next.out_class      = res_cls_reg;
            rsp_next.urgent_count   = tcpq_pkg::CNT_FIELD_W'(u_count_reg);
            rsp_next.normal_count   = tcpq_pkg::CNT_FIELD_W'(n_count_reg);
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            u_head_reg    <= '0;
            u_tail_reg    <= '0;
            u_count_reg   <= '0;
            n_head_reg    <= '0;
            n_tail_reg    <= '0;
            n_count_reg   <= '0;
            h_wr_reg      <= '0;
            h_count_reg   <= '0;
            scan_left_reg <= '0;
            pend_reg      <= 1'b0;
            src_reg       <= SRC_U;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            u_head_reg    <= u_head_next;
            u_tail_reg    <= u_tail_next;
            u_count_reg   <= u_count_next;
            n_head_reg    <= n_head_next;
            n_tail_reg    <= n_tail_next;
            n_count_reg   <= n_count_next;
            h_wr_reg      <= h_wr_next;
            h_count_reg   <= h_count_next;
            scan_left_reg <= scan_left_next;
            pend_reg      <= pend_next;
            src_reg       <= src_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        scan_addr_reg  <= scan_addr_next;
        key_reg        <= key_next;
        ref_reg        <= ref_next;
        cls_reg        <= cls_next;
        serve_reg      <= serve_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_ref_reg    <= res_ref_next;
        res_cls_reg    <= res_cls_next;
        rsp_reg        <= rsp_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // checks
    `TCPQ_ASSERT_NEXT(a_finish_loads, clk, rst_n,
        state_reg == ST_FINISH && can_load, rsp_valid_reg && state_reg == ST_IDLE,
        "finished result not loaded into output register")
    `TCPQ_ASSERT_NEXT(a_insert_grows, clk, rst_n, u_we,
        u_count_reg == $past(u_count_reg) + QCW'(1),
        "urgent write without count increment")
    `TCPQ_ASSERT(a_hist_monotonic, clk, rst_n,
        h_count_reg >= $past(h_count_reg),
        "history count decreased")

endmodule

/* test/tb_two_class_priority_queue_top.sv */
// ----------------------------------------------------------------------------
// tb_two_class_priority_queue_top
// Drives insert, serve and peek items into the two-class priority queue and
// checks every result item against a cycle-free model of the urgent and normal
// fifos and the served-id ring. A short directed list covers empty queues,
// duplicates and priority order. Random segments then fill a queue to full,
// drain it, and mix all kinds of items. The sender idles and the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb_two_class_priority_queue_top;
    timeunit 1ns;
    timeprecision 1ps;

    // kind code that the block treats as a no-op
    localparam logic [1:0] KIND_NONE = 2'd3;

    localparam int IDW = tcpq_pkg::ID_FIELD_W;
    localparam int IDB = tcpq_pkg::ID_BITS;
    localparam int RFW = tcpq_pkg::REF_W;
    localparam int CW  = tcpq_pkg::CNT_FIELD_W;
    localparam int QD  = tcpq_pkg::QUEUE_DEPTH;
    localparam int HD  = tcpq_pkg::HIST_DEPTH;

    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 150;
    localparam int RANDOM_ITEMS = 900;
    localparam int ID_SPAN      = 1 << IDW;
    localparam int REF_MAX      = (1 << RFW) - 1;

    typedef enum int { STALL_NONE, STALL_SCATTER, STALL_RUNS } stall_mode_e;

    typedef struct {
        tcpq_pkg::req_t item;
        bit             settle;   // hold off until every result is back
    } stim_t;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    tcpq_pkg::req_t req       = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    tcpq_pkg::rsp_t rsp;

    // pending items and expected results
    stim_t          stim_q [$];
    tcpq_pkg::rsp_t expected_q [$];
    int             predicted_cnt = 0;
    int             checked_cnt   = 0;
    int             fail_cnt      = 0;

    // id bookkeeping of the stimulus side
    bit id_used [ID_SPAN];
    int used_ids [$];

    // model of the two fifos (index 0 urgent, 1 normal) and the served-id ring
    logic [IDB-1:0] q_id  [2][QD];
    logic [RFW-1:0] q_rec [2][QD];
    int             q_head [2];
    int             q_tail [2];
    int             q_cnt  [2];
    logic [IDB-1:0] served_ids [HD];
    int             served_wr;
    int             served_cnt;

    // driver, receiver and watchdog state
    int             burst_left  = 1;
    int             gap_left    = 0;
    stall_mode_e    stall_mode  = STALL_NONE;
    int             mode_left   = 0;
    int             run_left    = 0;
    int             idle_cycles = 0;
    tcpq_pkg::rsp_t head_exp;

    two_class_priority_queue_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // apply one item to the queue model and return the result it gives
    function automatic tcpq_pkg::rsp_t queue_step(tcpq_pkg::req_t r);
        tcpq_pkg::rsp_t res;
        logic [IDB-1:0] id;
        bit             known;
        int             c;
        int             pos;
        res = '0;
        id = r.pet_id[IDB-1:0];
        case (r.kind)
        tcpq_pkg::KIND_INSERT:
        begin
            c = r.priority_class;
            known = 1'b0;
            // duplicate search over both fifos and the ring
            for (int k = 0; k < 2; k++)
            begin
                pos = q_head[k];
                for (int n = 0; n < q_cnt[k]; n++)
                begin
                    if (q_id[k][pos] == id)
                        known = 1'b1;
                    pos = (pos + 1) % QD;
                end
            end
            for (int i = 0; i < served_cnt; i++)
                if (served_ids[i] == id)
                    known = 1'b1;
            if (known)
                res.status = tcpq_pkg::STAT_DUP;
            else if (q_cnt[c] >= QD)
                res.status = tcpq_pkg::STAT_FULL;
            else
            begin
                res.status = tcpq_pkg::STAT_OK;
                q_id[c][q_tail[c]] = id;
                q_rec[c][q_tail[c]] = r.record_ref;
                q_tail[c] = (q_tail[c] + 1) % QD;
                q_cnt[c]++;
            end
        end
        tcpq_pkg::KIND_SERVE, tcpq_pkg::KIND_PEEK:
        begin
            // strict priority: urgent head first
            if (q_cnt[0] > 0)
                c = 0;
            else if (q_cnt[1] > 0)
                c = 1;
            else
                c = -1;
            if (c < 0)
                res.status = tcpq_pkg::STAT_EMPTY;
            else
            begin
                res.status = tcpq_pkg::STAT_OK;
                res.out_id = IDW'(q_id[c][q_head[c]]);
                res.out_record_ref = q_rec[c][q_head[c]];
                res.out_class = c[0];
                if (r.kind == tcpq_pkg::KIND_SERVE)
                begin
                    served_ids[served_wr] = q_id[c][q_head[c]];
                    q_head[c] = (q_head[c] + 1) % QD;
                    q_cnt[c]--;
                    served_wr = (served_wr + 1) % HD;
                    if (served_cnt < HD)
                        served_cnt++;
                end
            end
        end
        default:
            res.status = tcpq_pkg::STAT_OK;
        endcase
        res.urgent_count = CW'(q_cnt[0]);
        res.normal_count = CW'(q_cnt[1]);
        return res;
    endfunction

    // queue one item for the driver
    task automatic add_item(input logic [1:0] kind, input int id, input int rec,
                            input int cls, input bit settle);
        stim_t s;
        s.item.kind = kind;
        s.item.pet_id = IDW'(id);
        s.item.record_ref = RFW'(rec);
        s.item.priority_class = cls[0];
        s.settle = settle;
        if (kind == tcpq_pkg::KIND_INSERT && !id_used[s.item.pet_id])
        begin
            id_used[s.item.pet_id] = 1'b1;
            used_ids.push_back(int'(s.item.pet_id));
        end
        stim_q.push_back(s);
    endtask

    // id never inserted so far, as far as up to 65 draws find one
    function automatic int fresh_id();
        int id;
        id = $urandom_range(0, ID_SPAN - 1);
        for (int t = 0; t < 64 && id_used[id]; t++)
            id = $urandom_range(0, ID_SPAN - 1);
        return id;
    endfunction

    // sender: bursts and gaps, optional hold-off until all results are back
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                expected_q.push_back(queue_step(req));
                predicted_cnt++;
            end
            if (!req_valid || !req_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (stim_q.size() != 0
                         && (!stim_q[0].settle || predicted_cnt == checked_cnt))
                begin
                    req <= stim_q[0].item;
                    req_valid <= 1'b1;
                    void'(stim_q.pop_front());
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern: quiet, scattered, or long runs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode = stall_mode_e'($urandom_range(0, 2));
                mode_left = $urandom_range(20, 200);
            end
            else
                mode_left--;
            case (stall_mode)
            STALL_NONE:
                rsp_stall <= 1'b0;
            STALL_SCATTER:
                rsp_stall <= ($urandom_range(0, 2) == 0);
            default:
            begin
                if (run_left > 0)
                begin
                    run_left--;
                    rsp_stall <= 1'b1;
                end
                else
                begin
                    rsp_stall <= 1'b0;
                    run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : 0;
                end
            end
            endcase
        end
    end

    // result checker
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            checked_cnt <= 0;
        else if (rsp_valid && !rsp_stall)
        begin
            if (expected_q.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("unexpected result item: st=%0d id=%0d rec=%h",
                             rsp.status, rsp.out_id, rsp.out_record_ref,
                             " cls=%0d u=%0d n=%0d",
                             rsp.out_class, rsp.urgent_count, rsp.normal_count);
            end
            else
            begin
                head_exp = expected_q.pop_front();
                checked_cnt <= checked_cnt + 1;
                if (rsp.status !== head_exp.status || rsp.out_id !== head_exp.out_id
                    || rsp.out_record_ref !== head_exp.out_record_ref
                    || rsp.out_class !== head_exp.out_class
                    || rsp.urgent_count !== head_exp.urgent_count
                    || rsp.normal_count !== head_exp.normal_count)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("result %0d: exp st=%0d id=%0d rec=%h cls=%0d u=%0d n=%0d",
                                 checked_cnt, head_exp.status, head_exp.out_id,
                                 head_exp.out_record_ref, head_exp.out_class,
                                 head_exp.urgent_count, head_exp.normal_count,
                                 ", got st=%0d id=%0d rec=%h cls=%0d u=%0d n=%0d",
                                 rsp.status, rsp.out_id, rsp.out_record_ref, rsp.out_class,
                                 rsp.urgent_count, rsp.normal_count);
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int seg;
        int n;
        int cls;
        int last_id;
        int pick;
        int n_directed;
        bit settle_next;
        logic [1:0] mix_kind;

        // model at reset
        for (int c = 0; c < 2; c++)
        begin
            q_head[c] = 0;
            q_tail[c] = 0;
            q_cnt[c] = 0;
        end
        served_wr = 0;
        served_cnt = 0;

        // directed: empty queues, unused kind, extremes, duplicates, priority
        add_item(tcpq_pkg::KIND_SERVE,  ID_SPAN - 1, REF_MAX, 1, 1'b0);
        add_item(tcpq_pkg::KIND_PEEK,   0, 0, 0, 1'b0);
        add_item(KIND_NONE,             0, 0, 0, 1'b0);
        add_item(tcpq_pkg::KIND_INSERT, 0, 0, 0, 1'b0);
        add_item(tcpq_pkg::KIND_INSERT, ID_SPAN - 1, REF_MAX, 1, 1'b0);
        add_item(tcpq_pkg::KIND_INSERT, 0, 16'h1234, 1, 1'b0);
        add_item(tcpq_pkg::KIND_INSERT, ID_SPAN - 1, 16'h4321, 0, 1'b0);
        add_item(tcpq_pkg::KIND_PEEK,   7, 16'h0f0f, 1, 1'b0);
        add_item(tcpq_pkg::KIND_INSERT, 512, 16'h5555, 0, 1'b0);
        add_item(tcpq_pkg::KIND_SERVE,  0, 0, 0, 1'b0);
        add_item(tcpq_pkg::KIND_SERVE,  0, 0, 0, 1'b0);
        // id 0 now only in the served ring
        add_item(tcpq_pkg::KIND_INSERT, 0, 16'haaaa, 0, 1'b0);
        add_item(tcpq_pkg::KIND_PEEK,   0, 0, 0, 1'b0);
        add_item(tcpq_pkg::KIND_SERVE,  0, 0, 0, 1'b0);
        add_item(tcpq_pkg::KIND_SERVE,  0, 0, 0, 1'b0);
        add_item(tcpq_pkg::KIND_PEEK,   0, 0, 0, 1'b0);
        add_item(KIND_NONE,             ID_SPAN - 1, REF_MAX, 1, 1'b0);
        add_item(tcpq_pkg::KIND_INSERT, 10'h2aa, 16'haaaa, 1, 1'b0);
        add_item(tcpq_pkg::KIND_INSERT, 10'h155, 16'h5555, 0, 1'b0);
        add_item(tcpq_pkg::KIND_SERVE,  0, 0, 0, 1'b0);
        add_item(tcpq_pkg::KIND_SERVE,  0, 0, 0, 1'b0);
        n_directed = stim_q.size();

        // random segments: fill to full and drain, or a free mix
        settle_next = 1'b1;
        while (stim_q.size() < n_directed + RANDOM_ITEMS)
        begin
            seg = $urandom_range(0, 9);
            if (seg < 3)
            begin
                cls = $urandom_range(0, 1);
                n = $urandom_range(14, 18);
                last_id = 0;
                for (int i = 0; i < n; i++)
                begin
                    last_id = fresh_id();
                    add_item(tcpq_pkg::KIND_INSERT, last_id, $urandom_range(0, REF_MAX),
                             cls, (i == 0) && settle_next);
                end
                // waiting id aimed at a full fifo, then a new one
                add_item(tcpq_pkg::KIND_INSERT, last_id, $urandom_range(0, REF_MAX),
                         cls, 1'b0);
                add_item(tcpq_pkg::KIND_INSERT, fresh_id(), $urandom_range(0, REF_MAX),
                         cls, 1'b0);
                n = $urandom_range(10, 34);
                for (int i = 0; i < n; i++)
                begin
                    mix_kind = ($urandom_range(0, 3) == 0) ? tcpq_pkg::KIND_PEEK
                                                           : tcpq_pkg::KIND_SERVE;
                    add_item(mix_kind,
                             $urandom_range(0, ID_SPAN - 1), $urandom_range(0, REF_MAX),
                             $urandom_range(0, 1), 1'b0);
                end
            end
            else
            begin
                for (int i = 0; i < 30; i++)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 40)
                    begin
                        if (used_ids.size() != 0 && $urandom_range(0, 3) == 0)
                            last_id = used_ids[$urandom_range(0, used_ids.size() - 1)];
                        else
                            last_id = fresh_id();
                        add_item(tcpq_pkg::KIND_INSERT, last_id, $urandom_range(0, REF_MAX),
                                 $urandom_range(0, 1), (i == 0) && settle_next);
                    end
                    else
                    begin
                        if (pick < 75)
                            mix_kind = tcpq_pkg::KIND_SERVE;
                        else if (pick < 95)
                            mix_kind = tcpq_pkg::KIND_PEEK;
                        else
                            mix_kind = KIND_NONE;
                        add_item(mix_kind,
                                 $urandom_range(0, ID_SPAN - 1), $urandom_range(0, REF_MAX),
                                 $urandom_range(0, 1), (i == 0) && settle_next);
                    end
                end
            end
            settle_next = ($urandom_range(0, 4) == 0);
        end

        // reset, then run until every item is in and every result is back
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        while (stim_q.size() != 0 || req_valid || predicted_cnt != checked_cnt)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (expected_q.size() != 0)
        begin
            fail_cnt += expected_q.size();
            $display("%0d expected result items never arrived", expected_q.size());
        end
        if (fail_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/tcpq_pkg.sv
rtl/tcpq_ram.sv
rtl/tcpq_match.sv
rtl/two_class_priority_queue_top.sv
test/tb_two_class_priority_queue_top.sv
